// ----- rtl/krt_pkg.sv -----
`default_nettype none

package krt_pkg;

    localparam int VALUE_BITS = 16;
    localparam int CFG_IDX_BITS = 1;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_SCAN   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_STORED   = 3'd0,
        ST_DELETED  = 3'd1,
        ST_FOUND    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4,
        ST_MATCH    = 3'd5,
        ST_NONE     = 3'd6
    } t_status;

    localparam logic [CFG_IDX_BITS-1:0] CFG_RANGE_LOW  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RANGE_HIGH = 1'b1;

    localparam logic signed [VALUE_BITS-1:0] RANGE_LOW_RST  = 16'sd80;
    localparam logic signed [VALUE_BITS-1:0] RANGE_HIGH_RST = 16'sd90;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic issue;
        logic probe_ev;
        logic finish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic probe_push;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- rtl/krt_req_if.sv -----
`default_nettype none

interface krt_req_if
    import krt_pkg::*;
#(
    parameter int KEY_BITS = 48
);
    logic                          valid;
    logic                          ready;
    t_cmd                          command;
    logic [KEY_BITS-1:0]           key;
    logic signed [VALUE_BITS-1:0]  value;

    modport source (output valid, command, key, value, input ready);
    modport sink   (input valid, command, key, value, output ready);
endinterface

`default_nettype wire

// ----- rtl/krt_rsp_if.sv -----
`default_nettype none

interface krt_rsp_if
    import krt_pkg::*;
#(
    parameter int KEY_BITS = 48
);
    logic                          valid;
    logic                          ready;
    t_status                       status;
    logic [KEY_BITS-1:0]           out_key;
    logic signed [VALUE_BITS-1:0]  out_value;
    logic                          last;

    modport source (output valid, status, out_key, out_value, last, input ready);
    modport sink   (input valid, status, out_key, out_value, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/krt_ctrl.sv -----
`default_nettype none

module krt_ctrl
    import krt_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_req_valid,
    output logic                              o_req_ready,
    input  wire t_dp_status                   i_st,
    output t_dp_cmd                           o_cmd,
    output logic [$clog2(ENTRIES)-1:0]        o_addr
);

    localparam int AW = $clog2(ENTRIES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINISH
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_addr, n_addr;
    logic            r_more, n_more;
    logic            r_pvld, n_pvld;
    logic            stall;

    // a scan match waits while the held match cannot move to the output
    assign stall = r_pvld && i_st.probe_push && !i_st.out_free;

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        n_more  = r_more;
        n_pvld  = r_pvld;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_WALK;
                    n_addr       = '0;
                    n_more       = 1'b1;
                    n_pvld       = 1'b0;
                end
            end
            S_WALK: begin
                if (!stall) begin
                    o_cmd.probe_ev = r_pvld;
                    o_cmd.issue    = r_more;
                    n_pvld         = r_more;
                    if (r_more) begin
                        n_addr = r_addr + 1'b1;
                        if (r_addr == LAST_ADDR) begin
                            n_more = 1'b0;
                        end
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (i_st.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr  <= '0;
            r_more  <= 1'b0;
            r_pvld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_more  <= n_more;
            r_pvld  <= n_pvld;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_addr      = r_addr;

    a_finish_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) |-> (!r_more && !r_pvld))
        else $error("finish entered with slots still in flight");

    a_walk_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && !r_more && !stall) |=> (r_state == S_FINISH))
        else $error("walk did not hand over to finish");

endmodule

`default_nettype wire

// ----- rtl/krt_datapath.sv -----
`default_nettype none

module krt_datapath
    import krt_pkg::*;
#(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 48
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire t_dp_cmd                         i_cmd,
    input  wire logic [$clog2(ENTRIES)-1:0]      i_addr,
    output t_dp_status                           o_st,
    input  wire t_cmd                            i_command,
    input  wire logic [KEY_BITS-1:0]             i_key,
    input  wire logic signed [VALUE_BITS-1:0]    i_value,
    input  wire logic                            i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]         i_cfg_idx,
    input  wire logic [VALUE_BITS-1:0]           i_cfg_data,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output t_status                              o_status,
    output logic [KEY_BITS-1:0]                  o_key,
    output logic signed [VALUE_BITS-1:0]         o_value,
    output logic                                 o_last
);

    localparam int AW = $clog2(ENTRIES);

    // request
    t_cmd                          r_cmd;
    logic [KEY_BITS-1:0]           r_key;
    logic signed [VALUE_BITS-1:0]  r_val;

    // range bounds
    logic signed [VALUE_BITS-1:0]  r_lo, r_hi;

    // table
    logic [ENTRIES-1:0]            r_slot_vld;
    logic [KEY_BITS-1:0]           mem_key [ENTRIES];
    logic [VALUE_BITS-1:0]         mem_val [ENTRIES];

    // probe stage
    logic [KEY_BITS-1:0]           r_pk;
    logic signed [VALUE_BITS-1:0]  r_pv;
    logic                          r_pslot;
    logic [AW-1:0]                 r_pidx;

    // walk results
    logic                          r_hit_found, r_free_found;
    logic [AW-1:0]                 r_hit_idx, r_free_idx;
    logic signed [VALUE_BITS-1:0]  r_hit_val;

    // newest scan match, held until the next one shows whether it is last
    logic                          r_hold_vld;
    logic [KEY_BITS-1:0]           r_hold_key;
    logic signed [VALUE_BITS-1:0]  r_hold_val;

    // output register
    logic                          r_o_valid;
    t_status                       r_o_status;
    logic [KEY_BITS-1:0]           r_o_key;
    logic signed [VALUE_BITS-1:0]  r_o_value;
    logic                          r_o_last;

    logic                          key_match, in_range, scan_hit, probe_push;
    logic                          out_free, load_out;
    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic                          set_vld, clr_vld;
    t_status                       n_status;
    logic [KEY_BITS-1:0]           n_okey;
    logic signed [VALUE_BITS-1:0]  n_oval;
    logic                          n_olast;

    assign key_match  = r_pslot && (r_pk == r_key);
    assign in_range   = (r_pv >= r_lo) && (r_pv <= r_hi);
    assign scan_hit   = (r_cmd == CMD_SCAN) && r_pslot && in_range;
    assign probe_push = scan_hit && r_hold_vld;
    assign out_free   = !r_o_valid || i_ready;

    assign o_st.probe_push = probe_push;
    assign o_st.out_free   = out_free;

    // final action and result
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_hit_idx;
        set_vld   = 1'b0;
        clr_vld   = 1'b0;
        n_status  = ST_NOTFOUND;
        n_okey    = '0;
        n_oval    = '0;
        n_olast   = 1'b1;
        if (i_cmd.finish) begin
            case (r_cmd)
                CMD_INSERT: begin
                    if (r_hit_found) begin
                        mem_we   = 1'b1;
                        set_vld  = 1'b1;
                        n_status = ST_STORED;
                    end else if (r_free_found) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_free_idx;
                        set_vld   = 1'b1;
                        n_status  = ST_STORED;
                    end else begin
                        n_status = ST_FULL;
                    end
                end
                CMD_DELETE: begin
                    if (r_hit_found) begin
                        clr_vld  = 1'b1;
                        n_status = ST_DELETED;
                    end
                end
                CMD_LOOKUP: begin
                    if (r_hit_found) begin
                        n_status = ST_FOUND;
                        n_okey   = r_key;
                        n_oval   = r_hit_val;
                    end
                end
                CMD_SCAN: begin
                    if (r_hold_vld) begin
                        n_status = ST_MATCH;
                        n_okey   = r_hold_key;
                        n_oval   = r_hold_val;
                    end else begin
                        n_status = ST_NONE;
                    end
                end
                default: begin
                    n_status = ST_NOTFOUND;
                end
            endcase
        end else begin
            n_status = ST_MATCH;
            n_okey   = r_hold_key;
            n_oval   = r_hold_val;
            n_olast  = 1'b0;
        end
    end

    assign load_out = i_cmd.finish || (i_cmd.probe_ev && probe_push);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_key[mem_waddr] <= r_key;
            mem_val[mem_waddr] <= r_val;
        end
        if (i_cmd.issue) begin
            r_pk <= mem_key[i_addr];
            r_pv <= mem_val[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd <= i_command;
            r_key <= i_key;
            r_val <= i_value;
        end
        if (i_cmd.issue) begin
            r_pslot <= r_slot_vld[i_addr];
            r_pidx  <= i_addr;
        end
        if (i_cmd.probe_ev) begin
            if (key_match && !r_hit_found) begin
                r_hit_idx <= r_pidx;
                r_hit_val <= r_pv;
            end
            if (!r_pslot && !r_free_found) begin
                r_free_idx <= r_pidx;
            end
            if (scan_hit) begin
                r_hold_key <= r_pk;
                r_hold_val <= r_pv;
            end
        end
        if (load_out) begin
            r_o_status <= n_status;
            r_o_key    <= n_okey;
            r_o_value  <= n_oval;
            r_o_last   <= n_olast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo         <= RANGE_LOW_RST;
            r_hi         <= RANGE_HIGH_RST;
            r_slot_vld   <= '0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_hold_vld   <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RANGE_LOW:  r_lo <= i_cfg_data;
                    CFG_RANGE_HIGH: r_hi <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (set_vld) begin
                r_slot_vld[mem_waddr] <= 1'b1;
            end
            if (clr_vld) begin
                r_slot_vld[r_hit_idx] <= 1'b0;
            end
            if (i_cmd.accept) begin
                r_hit_found  <= 1'b0;
                r_free_found <= 1'b0;
                r_hold_vld   <= 1'b0;
            end else if (i_cmd.probe_ev) begin
                if (key_match) begin
                    r_hit_found <= 1'b1;
                end
                if (!r_pslot) begin
                    r_free_found <= 1'b1;
                end
                if (scan_hit) begin
                    r_hold_vld <= 1'b1;
                end
            end
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid  = r_o_valid;
    assign o_status = r_o_status;
    assign o_key    = r_o_key;
    assign o_value  = r_o_value;
    assign o_last   = r_o_last;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (!r_o_valid || i_ready))
        else $error("result register loaded while still held");

    a_finish_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!i_cmd.probe_ev && !i_cmd.issue && !i_cmd.accept))
        else $error("finish overlaps a walk command");

    a_insert_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_cmd == CMD_INSERT && (r_hit_found || r_free_found))
        |=> r_slot_vld[$past(mem_waddr)])
        else $error("stored slot not marked valid");

endmodule

`default_nettype wire

// ----- rtl/keyed_record_table.sv -----
// keyed_record_table: a table of ENTRIES records, each a KEY_BITS key and a
// signed 16-bit score, with insert, delete, lookup and range-scan requests.
// i_req (sink) carries command, key and value; o_rsp (source) carries status,
// out_key, out_value and last. Both use valid/ready, a transfer happens on a
// rising edge with both high. i_cfg_we/i_cfg_idx/i_cfg_data write range_low
// (index 0) and range_high (index 1); write them only while the block is idle.
// One request at a time: every request walks all slots through the single
// read port of the key/score memory, one slot a cycle unless a scan match
// stalls the walk, and ready returns once the request's result is loaded.
// Insert, delete and lookup give one result when the walk ends. A range scan
// gives one result per matching slot in slot order, the final one with last
// set, or a single scan-none result; each match waits for the next match or
// the end of the walk, since last is known only then.
// The result sits in an output register, so a stalled receiver only holds
// the walk when a further scan match has to move out, and the next request
// is accepted while the last result still waits.
// Reset (synchronous, active low) clears all slot valid bits and restores the
// bounds to 80 and 90; slot contents are not cleared, and a slot's contents
// are never used before they are written.
`default_nettype none

module keyed_record_table
    import krt_pkg::*;
#(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 48
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    krt_req_if.sink                        i_req,
    krt_rsp_if.source                      o_rsp,
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire logic [VALUE_BITS-1:0]     i_cfg_data
);

    t_dp_cmd                        dp_cmd;
    t_dp_status                     dp_st;
    logic [$clog2(ENTRIES)-1:0]     walk_addr;

    krt_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_st        (dp_st),
        .o_cmd       (dp_cmd),
        .o_addr      (walk_addr)
    );

    krt_datapath #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_addr     (walk_addr),
        .o_st       (dp_st),
        .i_command  (i_req.command),
        .i_key      (i_req.key),
        .i_value    (i_req.value),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_rsp.valid),
        .i_ready    (o_rsp.ready),
        .o_status   (o_rsp.status),
        .o_key      (o_rsp.out_key),
        .o_value    (o_rsp.out_value),
        .o_last     (o_rsp.last)
    );

endmodule

`default_nettype wire
